/* hdl/jse_pkg.sv */
package jse_pkg;

  localparam int unsigned REPL_LEN = 6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // one entry of the queue: every character that one item causes, in order:
  // opening quote, replacements for a broken sequence, the byte's own text,
  // replacements for a truncated sequence, closing quote
  typedef struct packed {
    logic            has_open;
    logic [1:0]      pre_repl;
    logic [2:0]      act_len;
    logic [5:0][7:0] act_chars;
    logic [1:0]      post_repl;
    logic            has_close;
    logic [4:0]      last_idx;
  } cmd_t;

  // characters of the \ufffd replacement
  function automatic logic [7:0] repl_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_BSLASH;
      3'd1:    c = "u";
      3'd2:    c = "f";
      3'd3:    c = "f";
      3'd4:    c = "f";
      default: c = "d";
    endcase
    return c;
  endfunction

endpackage

/* hdl/jse_front.sv */
module jse_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           carries_byte_i,
  input  logic           string_start_i,
  input  logic           string_end_i,
  output logic           push_o,
  output jse_pkg::cmd_t  cmd_o
);
  import jse_pkg::*;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  localparam logic [7:0] CONT_LO = 8'h80;
  localparam logic [7:0] CONT_HI = 8'hBF;

  logic [7:0]      lead_q, lead_d;
  logic [1:0][7:0] held_q, held_d;
  logic [1:0]      hc_q, hc_d;
  logic [2:0]      exp_q, exp_d;

  logic [1:0] hc_v;
  logic [2:0] exp_v;
  logic [7:0] lo, hi;
  logic       cont_ok;
  logic       fresh;
  logic [4:0] total;
  cmd_t       cmd;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'b0, d};
    end else begin
      c = 8'h57 + {4'b0, d};
    end
    return c;
  endfunction

  always_comb begin
    // a new string drops whatever sequence was pending
    exp_v = string_start_i ? 3'd0 : exp_q;
    hc_v  = string_start_i ? 2'd0 : hc_q;

    lo = CONT_LO;
    hi = CONT_HI;
    if (hc_v == 2'd0) begin
      case (lead_q)
        LEAD_E0: lo = 8'hA0;
        LEAD_ED: hi = 8'h9F;
        LEAD_F0: lo = 8'h90;
        LEAD_F4: hi = 8'h8F;
        default: ;
      endcase
    end
    cont_ok = (in_byte_i >= lo) && (in_byte_i <= hi) && (hc_v != 2'd3);

    lead_d = lead_q;
    held_d = held_q;
    exp_d  = exp_v;
    hc_d   = hc_v;
    fresh  = 1'b0;
    cmd    = '0;
    cmd.has_open = string_start_i;

    if (carries_byte_i) begin
      if (exp_v != 3'd0) begin
        if (cont_ok) begin
          if ({1'b0, hc_v} + 3'd2 >= exp_v) begin
            // sequence complete: lead, held bytes, this byte
            cmd.act_chars[0] = lead_q;
            cmd.act_chars[1] = (hc_v == 2'd0) ? in_byte_i : held_q[0];
            cmd.act_chars[2] = (hc_v == 2'd1) ? in_byte_i : held_q[1];
            cmd.act_chars[3] = in_byte_i;
            cmd.act_len      = {1'b0, hc_v} + 3'd2;
            exp_d = 3'd0;
            hc_d  = 2'd0;
          end else begin
            held_d[hc_v[0]] = in_byte_i;
            hc_d = hc_v + 2'd1;
          end
        end else begin
          // broken sequence: one replacement per byte held so far, lead included, then retry the byte
          cmd.pre_repl = hc_v + 2'd1;
          exp_d = 3'd0;
          hc_d  = 2'd0;
          fresh = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
    end

    if (fresh) begin
      if (in_byte_i >= 8'h80) begin
        if (in_byte_i inside {[8'hC2:8'hDF]}) begin
          lead_d = in_byte_i;
          exp_d  = 3'd2;
          hc_d   = 2'd0;
        end else if (in_byte_i inside {[8'hE0:8'hEF]}) begin
          lead_d = in_byte_i;
          exp_d  = 3'd3;
          hc_d   = 2'd0;
        end else if (in_byte_i inside {[8'hF0:8'hF4]}) begin
          lead_d = in_byte_i;
          exp_d  = 3'd4;
          hc_d   = 2'd0;
        end else begin
          for (int k = 0; k < REPL_LEN; k++) begin
            cmd.act_chars[k] = repl_char(3'(k));
          end
          cmd.act_len = 3'(REPL_LEN);
        end
      end else begin
        cmd.act_chars[0] = CH_BSLASH;
        cmd.act_len      = 3'd2;
        case (in_byte_i)
          CH_QUOTE:  cmd.act_chars[1] = CH_QUOTE;
          CH_BSLASH: cmd.act_chars[1] = CH_BSLASH;
          CH_BS:     cmd.act_chars[1] = "b";
          CH_FF:     cmd.act_chars[1] = "f";
          CH_LF:     cmd.act_chars[1] = "n";
          CH_CR:     cmd.act_chars[1] = "r";
          CH_TAB:    cmd.act_chars[1] = "t";
          default: begin
            if (in_byte_i < 8'h20) begin
              cmd.act_chars[1] = "u";
              cmd.act_chars[2] = "0";
              cmd.act_chars[3] = "0";
              cmd.act_chars[4] = hex_digit(in_byte_i[7:4]);
              cmd.act_chars[5] = hex_digit(in_byte_i[3:0]);
              cmd.act_len      = 3'd6;
            end else begin
              cmd.act_chars[0] = in_byte_i;
              cmd.act_len      = 3'd1;
            end
          end
        endcase
      end
    end

    if (string_end_i) begin
      if (exp_d != 3'd0) begin
        cmd.post_repl = hc_d + 2'd1;
      end
      exp_d = 3'd0;
      hc_d  = 2'd0;
      cmd.has_close = 1'b1;
    end

    total = 5'(cmd.has_open) + 5'(cmd.pre_repl) * 5'd6 + 5'(cmd.act_len)
          + 5'(cmd.post_repl) * 5'd6 + 5'(cmd.has_close);
    cmd.last_idx = total - 5'd1;
  end

  assign push_o = accept_i && (total != 5'd0);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= 3'd0;
      hc_q  <= 2'd0;
    end else if (accept_i) begin
      exp_q <= exp_d;
      hc_q  <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      lead_q <= lead_d;
      held_q <= held_d;
    end
  end

endmodule

/* hdl/jse_queue.sv */
module jse_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jse_pkg::cmd_t  wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jse_pkg::cmd_t  rdata_o
);
  import jse_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/jse_back.sv */
module jse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  jse_pkg::cmd_t  q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_char_o,
  output logic           run_last_o,
  output logic           string_done_o
);
  import jse_pkg::*;

  typedef enum logic [4:0] {
    PH_OPEN  = 5'b00001,
    PH_PRE   = 5'b00010,
    PH_ACT   = 5'b00100,
    PH_POST  = 5'b01000,
    PH_CLOSE = 5'b10000
  } phase_e;

  logic       active_q;
  cmd_t       cmd_q;
  phase_e     ph_q, ph_d;
  logic [2:0] sub_q, sub_d;
  logic [1:0] rep_q, rep_d;
  logic [4:0] pos_q;

  logic       ov_q;
  logic [7:0] char_q;
  logic       last_q, done_q;

  logic       cur_valid, adv, step, is_last, seg_end;
  cmd_t       cur_cmd;
  phase_e     cur_ph;
  logic [2:0] cur_sub;
  logic [1:0] cur_rep;
  logic [4:0] cur_pos;
  logic [7:0] cur_char;

  // next segment with characters in it, skipping empty ones
  function automatic phase_e after_phase(input cmd_t c, input phase_e p);
    phase_e r;
    case (p)
      PH_OPEN: begin
        if (c.pre_repl != 2'd0) r = PH_PRE;
        else if (c.act_len != 3'd0) r = PH_ACT;
        else if (c.post_repl != 2'd0) r = PH_POST;
        else r = PH_CLOSE;
      end
      PH_PRE: begin
        if (c.act_len != 3'd0) r = PH_ACT;
        else if (c.post_repl != 2'd0) r = PH_POST;
        else r = PH_CLOSE;
      end
      PH_ACT: begin
        if (c.post_repl != 2'd0) r = PH_POST;
        else r = PH_CLOSE;
      end
      default: r = PH_CLOSE;
    endcase
    return r;
  endfunction

  always_comb begin
    cur_valid = active_q || q_valid_i;
    cur_cmd   = active_q ? cmd_q : q_data_i;
    if (active_q) begin
      cur_ph = ph_q;
    end else if (q_data_i.has_open) begin
      cur_ph = PH_OPEN;
    end else begin
      cur_ph = after_phase(q_data_i, PH_OPEN);
    end
    cur_sub = active_q ? sub_q : 3'd0;
    cur_rep = active_q ? rep_q : 2'd0;
    cur_pos = active_q ? pos_q : 5'd0;

    adv     = !ov_q || out_ready_i;
    step    = cur_valid && adv;
    is_last = (cur_pos == cur_cmd.last_idx);

    case (cur_ph)
      PH_PRE: begin
        cur_char = repl_char(cur_sub);
        seg_end  = (cur_sub == 3'(REPL_LEN - 1)) && (cur_rep == cur_cmd.pre_repl - 2'd1);
      end
      PH_ACT: begin
        cur_char = cur_cmd.act_chars[cur_sub];
        seg_end  = (cur_sub == cur_cmd.act_len - 3'd1);
      end
      PH_POST: begin
        cur_char = repl_char(cur_sub);
        seg_end  = (cur_sub == 3'(REPL_LEN - 1)) && (cur_rep == cur_cmd.post_repl - 2'd1);
      end
      default: begin
        cur_char = CH_QUOTE;
        seg_end  = 1'b1;
      end
    endcase

    ph_d  = cur_ph;
    sub_d = cur_sub + 3'd1;
    rep_d = cur_rep;
    if (seg_end) begin
      ph_d  = after_phase(cur_cmd, cur_ph);
      sub_d = 3'd0;
      rep_d = 2'd0;
    end else if (cur_sub == 3'(REPL_LEN - 1)) begin
      // next \ufffd of the same run
      sub_d = 3'd0;
      rep_d = cur_rep + 2'd1;
    end
  end

  assign q_pop_o = step && !active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ph_q     <= PH_OPEN;
      sub_q    <= 3'd0;
      rep_q    <= 2'd0;
      pos_q    <= 5'd0;
      ov_q     <= 1'b0;
    end else begin
      if (adv) begin
        ov_q <= cur_valid;
      end
      if (step) begin
        active_q <= !is_last;
        ph_q     <= ph_d;
        sub_q    <= sub_d;
        rep_q    <= rep_d;
        pos_q    <= cur_pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      cmd_q  <= cur_cmd;
      char_q <= cur_char;
      last_q <= is_last;
      done_q <= (cur_ph == PH_CLOSE);
    end
  end

  assign out_valid_o   = ov_q;
  assign out_char_o    = char_q;
  assign run_last_o    = last_q;
  assign string_done_o = done_q;

endmodule

/* hdl/json_string_escaper_utf8.sv */
// Path: an accepted item is written into the queue; its characters then go through the output
// register. Throughput: one character per cycle from the back end while the output is not
// stalled; an item yields up to 25 characters, and one that yields none is not queued.
// A queue of QUEUE_DEPTH entries between classifier and character generator absorbs bursts.
// Reset (asynchronous, active low) empties the queue, drops any pending UTF-8 sequence and
// clears the output valid.
module json_string_escaper_utf8 #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic [1:0] s_axis_tuser_i,   // [0] carries_byte, [1] string_start
  input  logic       s_axis_tlast_i,   // string_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic       m_axis_tuser_o,   // string_done
  output logic       m_axis_tlast_o    // run_last
);
  import jse_pkg::*;

  logic accept;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_wdata, q_rdata;

  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  jse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (s_axis_tdata_i),
    .carries_byte_i (s_axis_tuser_i[0]),
    .string_start_i (s_axis_tuser_i[1]),
    .string_end_i   (s_axis_tlast_i),
    .push_o         (q_push),
    .cmd_o          (q_wdata)
  );

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  jse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_char_o    (m_axis_tdata_o),
    .run_last_o    (m_axis_tlast_o),
    .string_done_o (m_axis_tuser_o)
  );

  // the closing quote always ends its item's run
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("closing quote not marked last");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  // characters of one item follow without gaps
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside a run");

endmodule
